/* rtl/assert_macros.svh */
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define SRC_AST_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("src_chk: same-cycle property failed");

// Next-cycle implication, disabled while reset is low.
`define SRC_AST_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("src_chk: next-cycle property failed");

`endif

/* rtl/src_pkg.sv */
// Shared types, codes and helpers of the spectrum resample and combine block.
package src_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int NUM_W           = 63;

    localparam logic [1:0] ACT_APPEND = 2'd0;
    localparam logic [1:0] ACT_TARGET = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;

    localparam logic [2:0] MODE_PASS = 3'd0;
    localparam logic [2:0] MODE_ADDR = 3'd1;
    localparam logic [2:0] MODE_SUBR = 3'd2;
    localparam logic [2:0] MODE_MULR = 3'd3;
    localparam logic [2:0] MODE_DIVR = 3'd4;
    localparam logic [2:0] MODE_ADDC = 3'd5;
    localparam logic [2:0] MODE_MULC = 3'd6;

    localparam logic [1:0] CFG_OP_MODE   = 2'd0;
    localparam logic [1:0] CFG_CONST     = 2'd1;
    localparam logic [1:0] CFG_TGT_SCALE = 2'd2;
    localparam logic [1:0] CFG_REF_SCALE = 2'd3;

    localparam logic [1:0] ST_INTERP    = 2'd0;
    localparam logic [1:0] ST_NOBRACKET = 2'd1;
    localparam logic [1:0] ST_DIVZERO   = 2'd2;

    localparam logic [1:0] MS_SCALE  = 2'd0;
    localparam logic [1:0] MS_INTERP = 2'd1;
    localparam logic [1:0] MS_COMB   = 2'd2;

    localparam logic DS_INTERP = 1'b0;
    localparam logic DS_COMB   = 1'b1;

    localparam logic [2:0] RO_PASS = 3'd0;
    localparam logic [2:0] RO_ADD  = 3'd1;
    localparam logic [2:0] RO_SUB  = 3'd2;
    localparam logic [2:0] RO_ADDC = 3'd3;
    localparam logic [2:0] RO_MUL  = 3'd4;
    localparam logic [2:0] RO_DIVZ = 3'd5;
    localparam logic [2:0] RO_DIV  = 3'd6;

    typedef struct packed {
        logic       load;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       tw_en;
        logic       wr_en;
        logic       clr;
        logic       scan_clr;
        logic       rd_en;
        logic       div_start;
        logic       div_sel;
        logic       interp_en;
        logic       nobr_en;
        logic       res_en;
        logic [2:0] res_op;
        logic       out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] action;
        logic [2:0] op_mode;
        logic       found;
        logic       ref_zero;
        logic       div_done;
    } t_dp_sts;

    // Saturate a wide signed value to signed 32 bits.
    function automatic logic [31:0] sat_s32(input logic signed [65:0] v);
        logic [31:0] r;
        if (v > 66'sd2147483647) begin
            r = 32'h7FFF_FFFF;
        end else if (v < -66'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

/* rtl/src_div.sv */
// Restoring divider, one quotient bit per cycle.
module src_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [src_pkg::NUM_W-1:0]  i_num,
    input  logic [31:0]                i_den,
    output logic [src_pkg::NUM_W-1:0]  o_quot,
    output logic                       o_done
);
    localparam int SW = $clog2(src_pkg::NUM_W + 1);

    logic [src_pkg::NUM_W-1:0] r_q;
    logic [31:0]               r_rem;
    logic [31:0]               r_den;
    logic [SW-1:0]             r_step;
    logic                      r_busy;
    logic                      r_done;
    logic [32:0]               rem_sh;
    logic [32:0]               diff;

    assign rem_sh = {r_rem, r_q[src_pkg::NUM_W-1]};
    assign diff   = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= r_busy && (r_step == SW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= SW'(src_pkg::NUM_W);
            end else if (r_busy) begin
                r_step <= r_step - SW'(1);
                if (r_step == SW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            if (!diff[32]) begin
                r_rem <= diff[31:0];
                r_q   <= {r_q[src_pkg::NUM_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[31:0];
                r_q   <= {r_q[src_pkg::NUM_W-2:0], 1'b0};
            end
        end
    end

    assign o_quot = r_q;
    assign o_done = r_done;
endmodule

/* rtl/src_dp.sv */
// Datapath: configuration, reference table, multiplier, divider and result registers.
module src_dp #(
    parameter int DEPTH = src_pkg::TABLE_DEPTH_DEF,
    localparam int AW   = $clog2(DEPTH),
    localparam int CW   = AW + 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [31:0]          i_cfg_data,
    input  logic [1:0]           i_action,
    input  logic [31:0]          i_wavelength,
    input  logic signed [31:0]   i_flux,
    input  src_pkg::t_dp_cmd     i_cmd,
    input  logic [AW-1:0]        i_rd_addr,
    output src_pkg::t_dp_sts     o_sts,
    output logic [CW-1:0]        o_cnt,
    output logic [31:0]          o_out_wavelength,
    output logic signed [31:0]   o_out_flux,
    output logic [1:0]           o_status
);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    logic [31:0] mem_w [DEPTH];
    logic [31:0] mem_f [DEPTH];

    logic [2:0]  r_op_mode;
    logic [31:0] r_const, r_tscale, r_rscale;
    logic [CW-1:0] r_cnt;
    logic [31:0] r_last;
    logic [1:0]  r_action;
    logic [31:0] r_w, r_fl;
    logic signed [65:0] r_prod;
    logic [31:0] r_tw;
    logic        r_rd_vld, r_have_prev, r_found;
    logic [31:0] r_rd_w, r_rd_f, r_prev_w, r_prev_f;
    logic [31:0] r_c0, r_c1, r_d0, r_d1;
    logic [31:0] r_ref, r_res;
    logic [1:0]  r_status;
    logic [31:0] r_ow, r_of;
    logic [1:0]  r_os;

    logic signed [32:0] mul_a, mul_b;
    logic [64:0]  scale_sum;
    logic [31:0]  scaled;
    logic signed [32:0] delta;
    logic [32:0]  delta_abs;
    logic [31:0]  step;
    logic signed [65:0] d0x, interp_v, fl66, ref66, const66, mq, qx, dq;
    logic [31:0]  interp;
    logic [31:0]  flmag, refmag;
    logic         match;
    logic [src_pkg::NUM_W-1:0] div_num, div_q;
    logic [31:0]  div_den;
    logic         div_done;
    logic [31:0]  res_n;

    // Wavelength scaling: round half up, saturate.
    assign scale_sum = {1'b0, r_prod[63:0]} + 65'h2000_0000;
    assign scaled    = (|scale_sum[64:62]) ? 32'hFFFF_FFFF : scale_sum[61:30];

    assign delta     = $signed({r_d1[31], r_d1}) - $signed({r_d0[31], r_d0});
    assign delta_abs = delta[32] ? 33'(-delta) : 33'(delta);
    assign step      = r_prod[62:31];
    assign d0x       = {{34{r_d0[31]}}, r_d0};
    assign interp_v  = delta[32] ? d0x - $signed({34'd0, step}) : d0x + $signed({34'd0, step});
    assign interp    = src_pkg::sat_s32(interp_v);

    assign fl66    = {{34{r_fl[31]}}, r_fl};
    assign ref66   = {{34{r_ref[31]}}, r_ref};
    assign const66 = {{34{r_const[31]}}, r_const};
    assign mq      = (r_prod + 66'sd8388608) >>> 24;
    assign flmag   = r_fl[31] ? 32'(-r_fl) : r_fl;
    assign refmag  = r_ref[31] ? 32'(-r_ref) : r_ref;
    assign qx      = $signed({3'd0, div_q});
    assign dq      = (r_fl[31] ^ r_ref[31]) ? -qx : qx;

    assign match = r_rd_vld && r_have_prev && (r_prev_w <= r_tw) && (r_rd_w > r_tw);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.mul_sel)
            src_pkg::MS_SCALE: begin
                mul_a = {1'b0, r_w};
                mul_b = {1'b0, (r_action == src_pkg::ACT_APPEND) ? r_rscale : r_tscale};
            end
            src_pkg::MS_INTERP: begin
                mul_a = {1'b0, delta_abs[31:0]};
                mul_b = {2'b0, div_q[30:0]};
            end
            src_pkg::MS_COMB: begin
                mul_a = {r_fl[31], r_fl};
                mul_b = (r_op_mode == src_pkg::MODE_MULC) ? {r_const[31], r_const}
                                                          : {r_ref[31], r_ref};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        if (i_cmd.div_sel == src_pkg::DS_COMB) begin
            div_num = {7'd0, flmag, 24'd0};
            div_den = refmag;
        end else begin
            div_num = {r_tw - r_c0, 31'd0};
            div_den = r_c1 - r_c0;
        end
    end

    always_comb begin
        case (i_cmd.res_op)
            src_pkg::RO_ADD:  res_n = src_pkg::sat_s32(fl66 + ref66);
            src_pkg::RO_SUB:  res_n = src_pkg::sat_s32(fl66 - ref66);
            src_pkg::RO_ADDC: res_n = src_pkg::sat_s32(fl66 + const66);
            src_pkg::RO_MUL:  res_n = src_pkg::sat_s32(mq);
            src_pkg::RO_DIVZ: res_n = r_fl[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            src_pkg::RO_DIV:  res_n = src_pkg::sat_s32(dq);
            default:          res_n = r_fl;
        endcase
    end

    src_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_quot  (div_q),
        .o_done  (div_done)
    );

    // Control state: configuration, fill count, scan flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op_mode   <= src_pkg::MODE_PASS;
            r_const     <= '0;
            r_tscale    <= 32'h4000_0000;
            r_rscale    <= 32'h4000_0000;
            r_cnt       <= '0;
            r_last      <= '0;
            r_rd_vld    <= 1'b0;
            r_have_prev <= 1'b0;
            r_found     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    src_pkg::CFG_OP_MODE:   r_op_mode <= i_cfg_data[2:0];
                    src_pkg::CFG_CONST:     r_const   <= i_cfg_data;
                    src_pkg::CFG_TGT_SCALE: r_tscale  <= i_cfg_data;
                    src_pkg::CFG_REF_SCALE: r_rscale  <= i_cfg_data;
                    default:                r_const   <= r_const;
                endcase
            end
            if (i_cmd.clr) begin
                r_cnt  <= '0;
                r_last <= '0;
            end else begin
                if (i_cmd.wr_en && (r_cnt != DEPTH_C)) begin
                    r_cnt <= r_cnt + CW'(1);
                end
                if (i_cmd.interp_en) begin
                    r_last <= interp;
                end
            end
            r_rd_vld <= i_cmd.rd_en;
            if (i_cmd.scan_clr) begin
                r_have_prev <= 1'b0;
                r_found     <= 1'b0;
            end else if (r_rd_vld) begin
                r_have_prev <= 1'b1;
                if (match) begin
                    r_found <= 1'b1;
                end
            end
        end
    end

    // Table write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en && (r_cnt != DEPTH_C)) begin
            mem_w[r_cnt[AW-1:0]] <= scaled;
            mem_f[r_cnt[AW-1:0]] <= r_fl;
        end
        if (i_cmd.rd_en) begin
            r_rd_w <= mem_w[i_rd_addr];
            r_rd_f <= mem_f[i_rd_addr];
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_w      <= i_wavelength;
            r_fl     <= i_flux;
        end
        if (i_cmd.mul_en) begin
            r_prod <= mul_a * mul_b;
        end
        if (i_cmd.tw_en) begin
            r_tw     <= scaled;
            r_status <= src_pkg::ST_INTERP;
        end
        if (r_rd_vld) begin
            r_prev_w <= r_rd_w;
            r_prev_f <= r_rd_f;
            if (match) begin
                r_c0 <= r_prev_w;
                r_c1 <= r_rd_w;
                r_d0 <= r_prev_f;
                r_d1 <= r_rd_f;
            end
        end
        if (i_cmd.nobr_en) begin
            r_ref    <= r_last;
            r_status <= src_pkg::ST_NOBRACKET;
        end
        if (i_cmd.interp_en) begin
            r_ref <= interp;
        end
        if (i_cmd.res_en) begin
            r_res <= res_n;
            if (i_cmd.res_op == src_pkg::RO_DIVZ) begin
                r_status <= src_pkg::ST_DIVZERO;
            end
        end
        if (i_cmd.out_load) begin
            r_ow <= r_tw;
            r_of <= r_res;
            r_os <= r_status;
        end
    end

    assign o_sts.action   = r_action;
    assign o_sts.op_mode  = r_op_mode;
    assign o_sts.found    = r_found;
    assign o_sts.ref_zero = (r_ref == 32'd0);
    assign o_sts.div_done = div_done;
    assign o_cnt            = r_cnt;
    assign o_out_wavelength = r_ow;
    assign o_out_flux       = r_of;
    assign o_status         = r_os;
endmodule

/* rtl/src_ctrl.sv */
// Controller: sequences append, clear and target words through the datapath.
module src_ctrl #(
    parameter int DEPTH = src_pkg::TABLE_DEPTH_DEF,
    localparam int AW   = $clog2(DEPTH),
    localparam int CW   = AW + 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  src_pkg::t_dp_sts  i_sts,
    input  logic [CW-1:0]     i_cnt,
    output src_pkg::t_dp_cmd  o_cmd,
    output logic [AW-1:0]     o_rd_addr
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MULW  = 4'd1;
    localparam logic [3:0] S_SCL   = 4'd2;
    localparam logic [3:0] S_SCAN  = 4'd3;
    localparam logic [3:0] S_SCEND = 4'd4;
    localparam logic [3:0] S_FND   = 4'd5;
    localparam logic [3:0] S_IDIVW = 4'd6;
    localparam logic [3:0] S_IFIN  = 4'd7;
    localparam logic [3:0] S_COMB  = 4'd8;
    localparam logic [3:0] S_CMUL  = 4'd9;
    localparam logic [3:0] S_CDIVW = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    logic [3:0]    r_state, n_state;
    logic [AW-1:0] r_k, n_k;
    logic          r_out_vld, n_out_vld;
    logic          use_ref, k_last;

    assign use_ref = (i_sts.op_mode == src_pkg::MODE_ADDR) || (i_sts.op_mode == src_pkg::MODE_SUBR)
                  || (i_sts.op_mode == src_pkg::MODE_MULR) || (i_sts.op_mode == src_pkg::MODE_DIVR);
    assign k_last  = ({1'b0, r_k} + CW'(1)) == i_cnt;

    always_comb begin
        n_state   = r_state;
        n_k       = r_k;
        n_out_vld = r_out_vld && !i_out_ready;
        o_cmd     = '0;
        o_rd_addr = r_k;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MULW;
                end
            end
            S_MULW: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = src_pkg::MS_SCALE;
                n_state       = S_SCL;
            end
            S_SCL: begin
                o_cmd.tw_en    = 1'b1;
                o_cmd.scan_clr = 1'b1;
                n_k            = '0;
                n_state        = S_IDLE;
                case (i_sts.action)
                    src_pkg::ACT_APPEND: o_cmd.wr_en = 1'b1;
                    src_pkg::ACT_CLEAR:  o_cmd.clr   = 1'b1;
                    src_pkg::ACT_TARGET: begin
                        if (!use_ref) begin
                            n_state = S_COMB;
                        end else if (i_cnt == '0) begin
                            n_state = S_SCEND;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_SCAN: begin
                o_cmd.rd_en = 1'b1;
                if (k_last) begin
                    n_state = S_SCEND;
                end else begin
                    n_k = r_k + AW'(1);
                end
            end
            S_SCEND: begin
                n_state = S_FND;
            end
            S_FND: begin
                if (i_sts.found) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = src_pkg::DS_INTERP;
                    n_state         = S_IDIVW;
                end else begin
                    o_cmd.nobr_en = 1'b1;
                    n_state       = S_COMB;
                end
            end
            S_IDIVW: begin
                o_cmd.div_sel = src_pkg::DS_INTERP;
                if (i_sts.div_done) begin
                    o_cmd.mul_en  = 1'b1;
                    o_cmd.mul_sel = src_pkg::MS_INTERP;
                    n_state       = S_IFIN;
                end
            end
            S_IFIN: begin
                o_cmd.interp_en = 1'b1;
                n_state         = S_COMB;
            end
            S_COMB: begin
                o_cmd.div_sel = src_pkg::DS_COMB;
                case (i_sts.op_mode)
                    src_pkg::MODE_ADDR: begin
                        o_cmd.res_en = 1'b1;
                        o_cmd.res_op = src_pkg::RO_ADD;
                        n_state      = S_OUT;
                    end
                    src_pkg::MODE_SUBR: begin
                        o_cmd.res_en = 1'b1;
                        o_cmd.res_op = src_pkg::RO_SUB;
                        n_state      = S_OUT;
                    end
                    src_pkg::MODE_ADDC: begin
                        o_cmd.res_en = 1'b1;
                        o_cmd.res_op = src_pkg::RO_ADDC;
                        n_state      = S_OUT;
                    end
                    src_pkg::MODE_MULR, src_pkg::MODE_MULC: begin
                        o_cmd.mul_en  = 1'b1;
                        o_cmd.mul_sel = src_pkg::MS_COMB;
                        n_state       = S_CMUL;
                    end
                    src_pkg::MODE_DIVR: begin
                        if (i_sts.ref_zero) begin
                            o_cmd.res_en = 1'b1;
                            o_cmd.res_op = src_pkg::RO_DIVZ;
                            n_state      = S_OUT;
                        end else begin
                            o_cmd.div_start = 1'b1;
                            n_state         = S_CDIVW;
                        end
                    end
                    default: begin
                        o_cmd.res_en = 1'b1;
                        o_cmd.res_op = src_pkg::RO_PASS;
                        n_state      = S_OUT;
                    end
                endcase
            end
            S_CMUL: begin
                o_cmd.res_en = 1'b1;
                o_cmd.res_op = src_pkg::RO_MUL;
                n_state      = S_OUT;
            end
            S_CDIVW: begin
                o_cmd.div_sel = src_pkg::DS_COMB;
                if (i_sts.div_done) begin
                    o_cmd.res_en = 1'b1;
                    o_cmd.res_op = src_pkg::RO_DIV;
                    n_state      = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_vld || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_vld      = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_k       <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_k       <= n_k;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;
endmodule

/* rtl/spectrum_resample_combine.sv */
// Top level of the spectrum resample and combine block.
// Takes one input word at a time. Append and clear words pass through the
// scale multiply and the scale step before the next word can enter. A target
// word in the pass and add-constant modes goes on to the combine and output
// states, and the multiply-constant mode adds a product state. In the
// reference modes the controller scans the table once, one entry per cycle
// through the table's registered read port, then combines; multiply adds a
// product state. When a bracket is found, the bit-serial divider forms the
// interpolation fraction in 63 steps, and divide mode with a nonzero
// reference adds a second, combining division. Results leave through an
// output register, so the next input word is taken while a finished result
// still waits for i_out_ready. Configuration writes on i_cfg_we take effect
// at once and belong to idle periods only. The table needs no clearing after
// reset: only entries below the fill count are read.
module spectrum_resample_combine #(
    parameter int TABLE_DEPTH = src_pkg::TABLE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [31:0]         i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [1:0]          i_action,
    input  logic [31:0]         i_wavelength,
    input  logic signed [31:0]  i_flux,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [31:0]         o_out_wavelength,
    output logic signed [31:0]  o_out_flux,
    output logic [1:0]          o_status
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = AW + 1;

    // Command and status between sequencer and datapath.
    src_pkg::t_dp_cmd cmd;
    src_pkg::t_dp_sts sts;
    logic [CW-1:0]    cnt;
    logic [AW-1:0]    rd_addr;

    src_ctrl #(.DEPTH(TABLE_DEPTH)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .i_cnt       (cnt),
        .o_cmd       (cmd),
        .o_rd_addr   (rd_addr)
    );

    src_dp #(.DEPTH(TABLE_DEPTH)) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_action         (i_action),
        .i_wavelength     (i_wavelength),
        .i_flux           (i_flux),
        .i_cmd            (cmd),
        .i_rd_addr        (rd_addr),
        .o_sts            (sts),
        .o_cnt            (cnt),
        .o_out_wavelength (o_out_wavelength),
        .o_out_flux       (o_out_flux),
        .o_status         (o_status)
    );
endmodule

/* rtl/src_chk.sv */
// Port-level checker for the spectrum resample and combine block, with its bind.
`include "assert_macros.svh"

module src_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_out_wavelength,
    input logic [31:0] o_out_flux,
    input logic [1:0]  o_status
);
    logic        out_wait;
    logic [65:0] out_word;
    logic        in_take;
    logic        divz_word;
    logic        flux_sat;

    assign out_wait  = o_out_valid && !i_out_ready;
    assign out_word  = {o_out_wavelength, o_out_flux, o_status};
    assign in_take   = i_in_valid && o_in_ready;
    assign divz_word = o_out_valid && (o_status == src_pkg::ST_DIVZERO);
    assign flux_sat  = (o_out_flux == 32'h7FFF_FFFF) || (o_out_flux == 32'h8000_0000);

    // Hold a stalled result word.
    `SRC_AST_NEXT(a_out_hold, i_clk, i_rst_n, out_wait, o_out_valid && $stable(out_word))
    // One word at a time: ready drops after an accept.
    `SRC_AST_NEXT(a_one_busy, i_clk, i_rst_n, in_take, !o_in_ready)
    // A zero divisor gives a saturated flux.
    `SRC_AST_SAME(a_divz_sat, i_clk, i_rst_n, divz_word, flux_sat)
endmodule

bind spectrum_resample_combine src_chk u_src_chk (.*);
